### sv/tah_pkg.sv
// ----------------------------------------------------------------------------
// tah_pkg: shared types, constants and helpers for the tilt and heading block
// angle table, fixed-point widths and the small helpers used at the chain ends
// ----------------------------------------------------------------------------
`default_nettype none

package tah_pkg;

  // vectoring datapath, angle and rotation widths
  localparam int VW  = 34;
  localparam int ZW  = 27;
  localparam int RW  = 32;
  localparam int ATW = 23;

  // square root chains: radicand width and number of root bits
  localparam int SQ1W = 60;
  localparam int SQ1N = 30;
  localparam int SQ2W = 61;
  localparam int SQ2N = 31;

  // divider: remainder, divisor and quotient widths
  localparam int DVW = 61;
  localparam int MW  = 30;
  localparam int QW  = 31;

  // gravity register
  localparam int GW = 15;
  localparam logic [GW-1:0] G_RESET = 15'd16384;
  localparam logic GRAVITY_IDX = 1'b0;

  localparam logic signed [ZW-1:0] DEG90_Q16  = 27'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 27'sd11796480;
  localparam logic signed [ZW-1:0] HALF9      = 27'sd256;
  localparam logic signed [ZW-1:0] ROLL_LIM   = 27'sd23040;
  localparam logic signed [ZW-1:0] PITCH_LIM  = 27'sd11520;
  localparam logic signed [49:0]   HALF30     = 50'sd536870912;
  localparam logic signed [19:0]   SAT_LIM    = 20'sd32767;
  localparam logic [RW-1:0]        ONE_Q29    = 32'd536870912;

  typedef struct packed {
    logic [VW-1:0] x;
    logic [VW-1:0] y;
    logic [ZW-1:0] z;
    logic          zero;
  } vpre_t;

  typedef struct packed {
    logic [ZW-1:0] z;
    logic          neg;
  } fold_t;

  typedef struct packed {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
  } ang_t;

  // sideband through the roll / yaw vectoring chain
  typedef struct packed {
    logic [15:0] ax;
    logic [31:0] sumsq;
    logic [1:0]  zero;
  } pa_t;

  // sideband through the first square root chain
  typedef struct packed {
    logic [15:0]   ax;
    logic [ZW-1:0] roll_q;
    logic [ZW-1:0] yaw_q;
  } pb_t;

  // sideband through the pitch vectoring chain
  typedef struct packed {
    logic [ZW-1:0] roll_q;
    logic [ZW-1:0] yaw_q;
    logic          rzero;
    logic          ax_neg;
    logic          ax_pos;
  } pc_t;

  // sideband through the rotation chain
  typedef struct packed {
    logic [1:0] neg;
    ang_t       ang;
  } pd_t;

  // sideband through the second square root chain
  typedef struct packed {
    logic [1:0][RW-1:0] x;
    logic [1:0][RW-1:0] y;
    pd_t                d;
  } pe_t;

  // sideband through the divider chain
  typedef struct packed {
    logic [3:0] sign;
    ang_t       ang;
  } pf_t;

  function automatic logic [ATW-1:0] atan_q16(int i);
    case (i)
      0:  return 23'd2949120;
      1:  return 23'd1740967;
      2:  return 23'd919879;
      3:  return 23'd466945;
      4:  return 23'd234379;
      5:  return 23'd117304;
      6:  return 23'd58666;
      7:  return 23'd29335;
      8:  return 23'd14668;
      9:  return 23'd7334;
      10: return 23'd3667;
      11: return 23'd1833;
      12: return 23'd917;
      13: return 23'd458;
      14: return 23'd229;
      15: return 23'd115;
      16: return 23'd57;
      17: return 23'd29;
      18: return 23'd14;
      19: return 23'd7;
      20: return 23'd4;
      21: return 23'd2;
      22: return 23'd1;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] scale_in(logic signed [15:0] v);
    return {{(VW-30){v[15]}}, v, 14'b0};
  endfunction

  // quadrant handling ahead of the vectoring cells
  function automatic vpre_t vec_pre(logic signed [15:0] yin, logic signed [15:0] xin);
    vpre_t p;
    logic signed [VW-1:0] xv, yv;
    xv = scale_in(xin);
    yv = scale_in(yin);
    p.zero = (xin == 16'sd0) && (yin == 16'sd0);
    if (xv < 0) begin
      p.x = -xv;
      p.y = -yv;
      p.z = (yv >= 0) ? DEG180_Q16 : -DEG180_Q16;
    end else begin
      p.x = xv;
      p.y = yv;
      p.z = '0;
    end
    return p;
  endfunction

  // fold an angle beyond +-90 degrees by 180
  function automatic fold_t fold(logic signed [ZW-1:0] z);
    fold_t f;
    if (z > DEG90_Q16) begin
      f.z = z - DEG180_Q16;
      f.neg = 1'b1;
    end else if (z < -DEG90_Q16) begin
      f.z = z + DEG180_Q16;
      f.neg = 1'b1;
    end else begin
      f.z = z;
      f.neg = 1'b0;
    end
    return f;
  endfunction

  // q16 degrees to degrees*128, round half up, clamp
  function automatic logic [15:0] to_deg(logic signed [ZW-1:0] q, logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] t;
    t = (q + HALF9) >>> 9;
    if (t > lim) return lim[15:0];
    if (t < -lim) return 16'(-lim);
    return t[15:0];
  endfunction

  function automatic logic signed [19:0] rnd30(logic signed [49:0] p);
    logic signed [49:0] t;
    t = (p + HALF30) >>> 30;
    return t[19:0];
  endfunction

  function automatic logic [15:0] sat16(logic signed [19:0] v);
    if (v > SAT_LIM) return SAT_LIM[15:0];
    if (v < -SAT_LIM) return 16'(-SAT_LIM);
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

### sv/tah_vec_cell.sv
// ----------------------------------------------------------------------------
// tah_vec_cell: one vectoring step of the angle chain
// rotates each lane toward the x axis and accumulates the angle
// ----------------------------------------------------------------------------
`default_nettype none

module tah_vec_cell
  import tah_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][VW-1:0]  x_i,
  input  logic [LANES-1:0][VW-1:0]  y_i,
  input  logic [LANES-1:0][ZW-1:0]  z_i,
  input  logic [PW-1:0]             pass_i,
  output logic                      valid_o,
  output logic [LANES-1:0][VW-1:0]  x_o,
  output logic [LANES-1:0][VW-1:0]  y_o,
  output logic [LANES-1:0][ZW-1:0]  z_o,
  output logic [PW-1:0]             pass_o
);

  localparam logic [ZW-1:0] Ang = ZW'(atan_q16(STAGE));

  logic                     valid_q;
  logic [LANES-1:0][VW-1:0] x_q, x_d, y_q, y_d;
  logic [LANES-1:0][ZW-1:0] z_q, z_d;
  logic [PW-1:0]            pass_q;

  always_comb begin
    logic signed [VW-1:0] xv, yv, xs, ys;
    for (int l = 0; l < LANES; l++) begin
      xv = $signed(x_i[l]);
      yv = $signed(y_i[l]);
      xs = xv >>> STAGE;
      ys = yv >>> STAGE;
      if (yv >= 0) begin
        x_d[l] = xv + ys;
        y_d[l] = yv - xs;
        z_d[l] = z_i[l] + Ang;
      end else begin
        x_d[l] = xv - ys;
        y_d[l] = yv + xs;
        z_d[l] = z_i[l] - Ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

### sv/tah_rot_cell.sv
// ----------------------------------------------------------------------------
// tah_rot_cell: one rotation step of the sine / cosine chain
// turns each lane's vector by the table angle toward a zero residual
// ----------------------------------------------------------------------------
`default_nettype none

module tah_rot_cell
  import tah_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][RW-1:0]  x_i,
  input  logic [LANES-1:0][RW-1:0]  y_i,
  input  logic [LANES-1:0][ZW-1:0]  z_i,
  input  logic [PW-1:0]             pass_i,
  output logic                      valid_o,
  output logic [LANES-1:0][RW-1:0]  x_o,
  output logic [LANES-1:0][RW-1:0]  y_o,
  output logic [LANES-1:0][ZW-1:0]  z_o,
  output logic [PW-1:0]             pass_o
);

  localparam logic [ZW-1:0] Ang = ZW'(atan_q16(STAGE));

  logic                     valid_q;
  logic [LANES-1:0][RW-1:0] x_q, x_d, y_q, y_d;
  logic [LANES-1:0][ZW-1:0] z_q, z_d;
  logic [PW-1:0]            pass_q;

  always_comb begin
    logic signed [RW-1:0] xv, yv, xs, ys;
    for (int l = 0; l < LANES; l++) begin
      xv = $signed(x_i[l]);
      yv = $signed(y_i[l]);
      xs = xv >>> STAGE;
      ys = yv >>> STAGE;
      if (!z_i[l][ZW-1]) begin
        x_d[l] = xv - ys;
        y_d[l] = yv + xs;
        z_d[l] = z_i[l] - Ang;
      end else begin
        x_d[l] = xv + ys;
        y_d[l] = yv - xs;
        z_d[l] = z_i[l] + Ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

### sv/tah_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tah_sqrt_cell: one bit of a digit-by-digit integer square root
// trial subtract of the running root plus the stage's bit weight
// ----------------------------------------------------------------------------
`default_nettype none

module tah_sqrt_cell
  import tah_pkg::*;
#(
  parameter int BIT   = 0,
  parameter int NW    = 60,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][NW-1:0]  n_i,
  input  logic [LANES-1:0][NW-1:0]  r_i,
  input  logic [PW-1:0]             pass_i,
  output logic                      valid_o,
  output logic [LANES-1:0][NW-1:0]  n_o,
  output logic [LANES-1:0][NW-1:0]  r_o,
  output logic [PW-1:0]             pass_o
);

  localparam logic [NW:0] Wgt = (NW+1)'(1) << (2*BIT);

  logic                     valid_q;
  logic [LANES-1:0][NW-1:0] n_q, n_d, r_q, r_d;
  logic [PW-1:0]            pass_q;

  always_comb begin
    logic [NW:0] sum;
    logic        ge;
    for (int l = 0; l < LANES; l++) begin
      sum = {1'b0, r_i[l]} + Wgt;
      ge  = {1'b0, n_i[l]} >= sum;
      if (ge) begin
        n_d[l] = n_i[l] - sum[NW-1:0];
        r_d[l] = (r_i[l] >> 1) + Wgt[NW-1:0];
      end else begin
        n_d[l] = n_i[l];
        r_d[l] = r_i[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      r_q    <= r_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign r_o     = r_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

### sv/tah_div_cell.sv
// ----------------------------------------------------------------------------
// tah_div_cell: one quotient bit of a restoring unsigned divider
// compares the remainder with the shifted divisor and subtracts on a hit
// ----------------------------------------------------------------------------
`default_nettype none

module tah_div_cell
  import tah_pkg::*;
#(
  parameter int BIT   = 0,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][DVW-1:0] rem_i,
  input  logic [LANES-1:0][MW-1:0]  div_i,
  input  logic [LANES-1:0][QW-1:0]  q_i,
  input  logic [PW-1:0]             pass_i,
  output logic                      valid_o,
  output logic [LANES-1:0][DVW-1:0] rem_o,
  output logic [LANES-1:0][MW-1:0]  div_o,
  output logic [LANES-1:0][QW-1:0]  q_o,
  output logic [PW-1:0]             pass_o
);

  logic                      valid_q;
  logic [LANES-1:0][DVW-1:0] rem_q, rem_d;
  logic [LANES-1:0][MW-1:0]  div_q;
  logic [LANES-1:0][QW-1:0]  q_q, q_d;
  logic [PW-1:0]             pass_q;

  always_comb begin
    logic [DVW-1:0] trial;
    logic           ge;
    for (int l = 0; l < LANES; l++) begin
      trial  = DVW'(div_i[l]) << BIT;
      ge     = rem_i[l] >= trial;
      rem_d[l] = ge ? rem_i[l] - trial : rem_i[l];
      q_d[l]      = q_i[l];
      q_d[l][BIT] = ge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      q_q    <= q_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign q_o     = q_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

### sv/tilt_and_heading_angles.sv
// ----------------------------------------------------------------------------
// tilt_and_heading_angles: roll, pitch, heading and projected gravity
// one sensor sample in, one set of angles and gravity components out
// ----------------------------------------------------------------------------
// usage
//   input channel: accel_x/y/z and mag_x/y, taken when in_valid_i && in_ready_o
//   output channel: roll/pitch/yaw in degrees*128 and grav_x/y/z, handed over
//   when out_valid_o && out_ready_i; results come out in input order
//   config: apb write of gravity_magnitude at address 0, only while idle
// throughput: one item per cycle while the chain is not stalled; the vectoring,
//   rotation, root and divide units are chains of cells, one step of cordic,
//   square root or division per cell, all advancing together
// path: input register, roll/yaw vectoring, 30-bit root, pitch vectoring,
//   angle and fold register, sine/cosine rotation, squares register, 31-bit root
//   of the vector length, 31-bit normalizing divide, gravity math, result register
// stall: the whole chain holds while the output register is full and not
//   taken; in_ready_o drops in the same cycle, no item is dropped
// reset: clears all valid flags and loads gravity_magnitude with one g
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_and_heading_angles
  import tah_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] accel_x_i,
  input  logic [15:0] accel_y_i,
  input  logic [15:0] accel_z_i,
  input  logic [15:0] mag_x_i,
  input  logic [15:0] mag_y_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] roll_deg_o,
  output logic [14:0] pitch_deg_o,
  output logic [15:0] yaw_deg_o,
  output logic [15:0] grav_x_o,
  output logic [15:0] grav_y_o,
  output logic [15:0] grav_z_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int S   = CORDIC_STAGES;
  localparam int PAW = $bits(pa_t);
  localparam int PBW = $bits(pb_t);
  localparam int PCW = $bits(pc_t);
  localparam int PDW = $bits(pd_t);
  localparam int PEW = $bits(pe_t);
  localparam int PFW = $bits(pf_t);

  // global advance: the chain moves unless the result register is stuck
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // gravity magnitude register
  logic [GW-1:0] g_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= G_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == GRAVITY_IDX)) begin
      g_q <= pwdata[GW-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[2] == GRAVITY_IDX) ? {{(32-GW){1'b0}}, g_q} : '0;

  // ---------------- input register with quadrant handling ----------------
  vpre_t pre_roll, pre_yaw;
  assign pre_roll = vec_pre(accel_y_i, accel_z_i);
  assign pre_yaw  = vec_pre(mag_y_i, mag_x_i);

  logic                 s0_valid_q;
  logic [1:0][VW-1:0]   s0_x_q, s0_y_q;
  logic [1:0][ZW-1:0]   s0_z_q;
  pa_t                  s0_p_q;
  logic [31:0]          sumsq;

  assign sumsq = 32'($signed(accel_y_i) * $signed(accel_y_i))
               + 32'($signed(accel_z_i) * $signed(accel_z_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q       <= {pre_yaw.x, pre_roll.x};
      s0_y_q       <= {pre_yaw.y, pre_roll.y};
      s0_z_q       <= {pre_yaw.z, pre_roll.z};
      s0_p_q.ax    <= accel_x_i;
      s0_p_q.sumsq <= sumsq;
      s0_p_q.zero  <= {pre_yaw.zero, pre_roll.zero};
    end
  end

  // ---------------- roll (lane 0) and yaw (lane 1) vectoring ----------------
  logic               a_v [0:S];
  logic [1:0][VW-1:0] a_x [0:S];
  logic [1:0][VW-1:0] a_y [0:S];
  logic [1:0][ZW-1:0] a_z [0:S];
  logic [PAW-1:0]     a_p [0:S];

  assign a_v[0] = s0_valid_q;
  assign a_x[0] = s0_x_q;
  assign a_y[0] = s0_y_q;
  assign a_z[0] = s0_z_q;
  assign a_p[0] = s0_p_q;

  for (genvar s = 0; s < S; s++) begin : g_vec_a
    tah_vec_cell #(.STAGE(s), .LANES(2), .PW(PAW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(a_v[s]), .x_i(a_x[s]), .y_i(a_y[s]), .z_i(a_z[s]), .pass_i(a_p[s]),
      .valid_o(a_v[s+1]), .x_o(a_x[s+1]), .y_o(a_y[s+1]), .z_o(a_z[s+1]),
      .pass_o(a_p[s+1])
    );
  end

  // ---------------- root of ay^2 + az^2 ----------------
  pa_t a_end;
  pb_t b_start;
  assign a_end          = pa_t'(a_p[S]);
  assign b_start.ax     = a_end.ax;
  assign b_start.roll_q = a_end.zero[0] ? '0 : a_z[S][0];
  assign b_start.yaw_q  = a_end.zero[1] ? '0 : a_z[S][1];

  logic                 b_v [0:SQ1N];
  logic [0:0][SQ1W-1:0] b_n [0:SQ1N];
  logic [0:0][SQ1W-1:0] b_r [0:SQ1N];
  logic [PBW-1:0]       b_p [0:SQ1N];

  assign b_v[0] = a_v[S];
  assign b_n[0] = {a_end.sumsq, 28'b0};
  assign b_r[0] = '0;
  assign b_p[0] = b_start;

  for (genvar s = 0; s < SQ1N; s++) begin : g_sqrt_b
    tah_sqrt_cell #(.BIT(SQ1N-1-s), .NW(SQ1W), .LANES(1), .PW(PBW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(b_v[s]), .n_i(b_n[s]), .r_i(b_r[s]), .pass_i(b_p[s]),
      .valid_o(b_v[s+1]), .n_o(b_n[s+1]), .r_o(b_r[s+1]), .pass_o(b_p[s+1])
    );
  end

  // ---------------- pitch vectoring ----------------
  pb_t                  b_end;
  pc_t                  c_start;
  logic signed [VW-1:0] ax_scaled;
  assign b_end            = pb_t'(b_p[SQ1N]);
  assign ax_scaled        = scale_in(b_end.ax);
  assign c_start.roll_q   = b_end.roll_q;
  assign c_start.yaw_q    = b_end.yaw_q;
  assign c_start.rzero    = (b_r[SQ1N][0] == '0);
  assign c_start.ax_neg   = b_end.ax[15];
  assign c_start.ax_pos   = !b_end.ax[15] && (b_end.ax != '0);

  logic               c_v [0:S];
  logic [0:0][VW-1:0] c_x [0:S];
  logic [0:0][VW-1:0] c_y [0:S];
  logic [0:0][ZW-1:0] c_z [0:S];
  logic [PCW-1:0]     c_p [0:S];

  assign c_v[0] = b_v[SQ1N];
  assign c_x[0] = b_r[SQ1N][0][VW-1:0];
  assign c_y[0] = -ax_scaled;
  assign c_z[0] = '0;
  assign c_p[0] = c_start;

  for (genvar s = 0; s < S; s++) begin : g_vec_c
    tah_vec_cell #(.STAGE(s), .LANES(1), .PW(PCW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(c_v[s]), .x_i(c_x[s]), .y_i(c_y[s]), .z_i(c_z[s]), .pass_i(c_p[s]),
      .valid_o(c_v[s+1]), .x_o(c_x[s+1]), .y_o(c_y[s+1]), .z_o(c_z[s+1]),
      .pass_o(c_p[s+1])
    );
  end

  // ---------------- angle outputs and folding ----------------
  pc_t           c_end;
  logic [ZW-1:0] pitch_q;
  fold_t         fold_roll, fold_pitch;
  assign c_end = pc_t'(c_p[S]);

  // flat accel vector in y/z: pitch is exactly +-90 or zero
  always_comb begin
    if (!c_end.rzero) begin
      pitch_q = c_z[S][0];
    end else if (c_end.ax_neg) begin
      pitch_q = DEG90_Q16;
    end else if (c_end.ax_pos) begin
      pitch_q = -DEG90_Q16;
    end else begin
      pitch_q = '0;
    end
  end

  assign fold_roll  = fold(c_end.roll_q);
  assign fold_pitch = fold(pitch_q);

  logic               d0_valid_q;
  logic [1:0][ZW-1:0] d0_z_q;
  pd_t                d0_p_q;
  logic [15:0]        pitch_deg16;
  assign pitch_deg16 = to_deg(pitch_q, PITCH_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_valid_q <= 1'b0;
    end else if (en) begin
      d0_valid_q <= c_v[S];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_z_q           <= {fold_pitch.z, fold_roll.z};
      d0_p_q.neg       <= {fold_pitch.neg, fold_roll.neg};
      d0_p_q.ang.roll  <= to_deg(c_end.roll_q, ROLL_LIM);
      d0_p_q.ang.pitch <= pitch_deg16[14:0];
      d0_p_q.ang.yaw   <= to_deg(c_end.yaw_q, ROLL_LIM);
    end
  end

  // ---------------- sine / cosine rotation, roll lane 0, pitch lane 1 ----------------
  logic               d_v [0:S];
  logic [1:0][RW-1:0] d_x [0:S];
  logic [1:0][RW-1:0] d_y [0:S];
  logic [1:0][ZW-1:0] d_z [0:S];
  logic [PDW-1:0]     d_p [0:S];

  assign d_v[0] = d0_valid_q;
  assign d_x[0] = {ONE_Q29, ONE_Q29};
  assign d_y[0] = '0;
  assign d_z[0] = d0_z_q;
  assign d_p[0] = d0_p_q;

  for (genvar s = 0; s < S; s++) begin : g_rot_d
    tah_rot_cell #(.STAGE(s), .LANES(2), .PW(PDW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(d_v[s]), .x_i(d_x[s]), .y_i(d_y[s]), .z_i(d_z[s]), .pass_i(d_p[s]),
      .valid_o(d_v[s+1]), .x_o(d_x[s+1]), .y_o(d_y[s+1]), .z_o(d_z[s+1]),
      .pass_o(d_p[s+1])
    );
  end

  // ---------------- squares of the rotated vectors ----------------
  logic                   e0_valid_q;
  logic [1:0][SQ1W-1:0]   e0_sx_q, e0_sy_q;
  pe_t                    e0_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_valid_q <= 1'b0;
    end else if (en) begin
      e0_valid_q <= d_v[S];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        e0_sx_q[l] <= SQ1W'($signed(d_x[S][l]) * $signed(d_x[S][l]));
        e0_sy_q[l] <= SQ1W'($signed(d_y[S][l]) * $signed(d_y[S][l]));
      end
      e0_p_q.x <= d_x[S];
      e0_p_q.y <= d_y[S];
      e0_p_q.d <= pd_t'(d_p[S]);
    end
  end

  // ---------------- vector length roots ----------------
  logic                 e_v [0:SQ2N];
  logic [1:0][SQ2W-1:0] e_n [0:SQ2N];
  logic [1:0][SQ2W-1:0] e_r [0:SQ2N];
  logic [PEW-1:0]       e_p [0:SQ2N];

  assign e_v[0] = e0_valid_q;
  assign e_n[0] = {SQ2W'(e0_sx_q[1]) + SQ2W'(e0_sy_q[1]),
                   SQ2W'(e0_sx_q[0]) + SQ2W'(e0_sy_q[0])};
  assign e_r[0] = '0;
  assign e_p[0] = e0_p_q;

  for (genvar s = 0; s < SQ2N; s++) begin : g_sqrt_e
    tah_sqrt_cell #(.BIT(SQ2N-1-s), .NW(SQ2W), .LANES(2), .PW(PEW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(e_v[s]), .n_i(e_n[s]), .r_i(e_r[s]), .pass_i(e_p[s]),
      .valid_o(e_v[s+1]), .n_o(e_n[s+1]), .r_o(e_r[s+1]), .pass_o(e_p[s+1])
    );
  end

  // ---------------- normalizing divide ----------------
  // lanes: 0 cos roll, 1 sin roll, 2 cos pitch, 3 sin pitch
  pe_t                 e_end;
  logic [1:0][MW-1:0]  mag;
  logic [3:0][RW-1:0]  num;
  logic [3:0]          num_neg;
  logic [3:0][DVW-1:0] f_rem0;
  logic [3:0][MW-1:0]  f_div0;
  pf_t                 f_start;

  assign e_end = pe_t'(e_p[SQ2N]);
  assign num   = {e_end.y[1], e_end.x[1], e_end.y[0], e_end.x[0]};
  assign num_neg = {e_end.d.neg[1], e_end.d.neg[1], e_end.d.neg[0], e_end.d.neg[0]};

  always_comb begin
    logic [RW-1:0] absv;
    for (int l = 0; l < 2; l++) begin
      mag[l] = (e_r[SQ2N][l][MW-1:0] == '0) ? MW'(1) : e_r[SQ2N][l][MW-1:0];
    end
    for (int l = 0; l < 4; l++) begin
      absv            = num[l][RW-1] ? -num[l] : num[l];
      f_rem0[l]       = DVW'(absv) << 30;
      f_div0[l]       = mag[l/2];
      f_start.sign[l] = num[l][RW-1] ^ num_neg[l];
    end
    f_start.ang = e_end.d.ang;
  end

  logic                f_v [0:QW];
  logic [3:0][DVW-1:0] f_rem [0:QW];
  logic [3:0][MW-1:0]  f_div [0:QW];
  logic [3:0][QW-1:0]  f_q [0:QW];
  logic [PFW-1:0]      f_p [0:QW];

  assign f_v[0]   = e_v[SQ2N];
  assign f_rem[0] = f_rem0;
  assign f_div[0] = f_div0;
  assign f_q[0]   = '0;
  assign f_p[0]   = f_start;

  for (genvar s = 0; s < QW; s++) begin : g_div_f
    tah_div_cell #(.BIT(QW-1-s), .LANES(4), .PW(PFW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(f_v[s]), .rem_i(f_rem[s]), .div_i(f_div[s]), .q_i(f_q[s]),
      .pass_i(f_p[s]),
      .valid_o(f_v[s+1]), .rem_o(f_rem[s+1]), .div_o(f_div[s+1]), .q_o(f_q[s+1]),
      .pass_o(f_p[s+1])
    );
  end

  // ---------------- gravity projection ----------------
  pf_t                f_end;
  logic [3:0][RW-1:0] trig;
  logic signed [15:0] g_s;
  assign f_end = pf_t'(f_p[QW]);
  assign g_s   = $signed({1'b0, g_q});

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trig[l] = f_end.sign[l] ? -RW'(f_q[QW][l]) : RW'(f_q[QW][l]);
    end
  end

  // g1: g times sin pitch, sin roll, cos roll
  logic               g1_valid_q;
  logic signed [47:0] g1_sp_q, g1_sr_q, g1_cr_q;
  logic [RW-1:0]      g1_cp_q;
  ang_t               g1_ang_q;

  // g2: rounded products, grav_x finished
  logic               g2_valid_q;
  logic [15:0]        g2_gx_q;
  logic [17:0]        g2_tsr_q, g2_tcr_q;
  logic [RW-1:0]      g2_cp_q;
  ang_t               g2_ang_q;

  // g3: second products by cos pitch
  logic               g3_valid_q;
  logic signed [49:0] g3_my_q, g3_mz_q;
  logic [15:0]        g3_gx_q;
  ang_t               g3_ang_q;

  logic signed [19:0] rsp, rsr, rcr;
  assign rsp = rnd30(50'(g1_sp_q));
  assign rsr = rnd30(50'(g1_sr_q));
  assign rcr = rnd30(50'(g1_cr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_valid_q <= 1'b0;
      g2_valid_q <= 1'b0;
      g3_valid_q <= 1'b0;
    end else if (en) begin
      g1_valid_q <= f_v[QW];
      g2_valid_q <= g1_valid_q;
      g3_valid_q <= g2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_sp_q  <= g_s * $signed(trig[3]);
      g1_sr_q  <= g_s * $signed(trig[1]);
      g1_cr_q  <= g_s * $signed(trig[0]);
      g1_cp_q  <= trig[2];
      g1_ang_q <= f_end.ang;

      g2_gx_q  <= sat16(-rsp);
      g2_tsr_q <= rsr[17:0];
      g2_tcr_q <= rcr[17:0];
      g2_cp_q  <= g1_cp_q;
      g2_ang_q <= g1_ang_q;

      g3_my_q  <= $signed(g2_tsr_q) * $signed(g2_cp_q);
      g3_mz_q  <= $signed(g2_tcr_q) * $signed(g2_cp_q);
      g3_gx_q  <= g2_gx_q;
      g3_ang_q <= g2_ang_q;
    end
  end

  // ---------------- result register ----------------
  ang_t        out_ang_q;
  logic [15:0] out_gx_q, out_gy_q, out_gz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= g3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ang_q <= g3_ang_q;
      out_gx_q  <= g3_gx_q;
      out_gy_q  <= sat16(rnd30(g3_my_q));
      out_gz_q  <= sat16(rnd30(g3_mz_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_deg_o  = out_ang_q.roll;
  assign pitch_deg_o = out_ang_q.pitch;
  assign yaw_deg_o   = out_ang_q.yaw;
  assign grav_x_o    = out_gx_q;
  assign grav_y_o    = out_gy_q;
  assign grav_z_o    = out_gz_q;

endmodule

`default_nettype wire
